>>> src/assert_macros.svh
// Assertion macros used by the RTL of the point-to-ray unit.
// Each macro expands to one labelled concurrent assertion that is
// clocked on the rising edge and disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked every clock outside reset.
`define PRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define PRD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Field widths, saturation limits and the result record of the
// point-to-ray distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

  // Widths of the transfer fields.
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned DIST_W   = 63;
  localparam int unsigned T_W      = 31;

  // Saturation limits of the results.
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [T_W-1:0]    T_MAX    = {T_W{1'b1}};

  // One result as it waits in the output or skid register.
  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic [T_W-1:0]    param_t;
    logic              hit;
  } res_t;

endpackage

`default_nettype wire

>>> src/prd_if.sv
// ----------------------------------------------------------------------------
// prd_in_if / prd_out_if
// Valid/ready channels carrying the query and the result of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface prd_in_if;
  logic                              valid;
  logic                              ready;
  logic [prd_pkg::FIELD_W-1:0]       point_x;
  logic [prd_pkg::FIELD_W-1:0]       point_y;
  logic [prd_pkg::FIELD_W-1:0]       point_z;
  logic [prd_pkg::FIELD_W-1:0]       origin_x;
  logic [prd_pkg::FIELD_W-1:0]       origin_y;
  logic [prd_pkg::FIELD_W-1:0]       origin_z;
  logic [prd_pkg::FIELD_W-1:0]       dir_x;
  logic [prd_pkg::FIELD_W-1:0]       dir_y;
  logic [prd_pkg::FIELD_W-1:0]       dir_z;
  logic [prd_pkg::RADIUS_W-1:0]      radius;

  modport source (
    output valid, point_x, point_y, point_z, origin_x, origin_y, origin_z,
           dir_x, dir_y, dir_z, radius,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, origin_x, origin_y, origin_z,
           dir_x, dir_y, dir_z, radius,
    output ready
  );
endinterface

interface prd_out_if;
  logic                         valid;
  logic                         ready;
  logic [prd_pkg::DIST_W-1:0]   dist_sq;
  logic [prd_pkg::T_W-1:0]      param_t;
  logic                         hit;

  modport source (output valid, dist_sq, param_t, hit, input ready);
  modport sink   (input valid, dist_sq, param_t, hit, output ready);
endinterface

`default_nettype wire

>>> src/prd_div_cell.sv
// ----------------------------------------------------------------------------
// prd_div_cell
// One step of a pipelined restoring divider: decides one quotient bit and
// hands the partial remainder, divisor and quotient to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_div_cell #(
  parameter int unsigned RW    = 101,
  parameter int unsigned DW    = 65,
  parameter int unsigned QB    = 34,
  parameter int unsigned SHIFT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [DW-1:0] div_i,
  input  wire logic [QB-1:0] quot_i,
  output logic      [RW-1:0] rem_o,
  output logic      [DW-1:0] div_o,
  output logic      [QB-1:0] quot_o
);

  localparam int unsigned CW = ((RW > DW + SHIFT) ? RW : DW + SHIFT) + 1;

  logic [CW-1:0] rem_ext;
  logic [CW-1:0] div_sh;
  logic [CW-1:0] diff;
  logic          ge;

  // Trial subtraction of the divisor weighted by this cell's bit.
  always_comb begin
    rem_ext = CW'(rem_i);
    div_sh  = CW'(div_i) << SHIFT;
    ge      = rem_ext >= div_sh;
    diff    = rem_ext - div_sh;
  end

  // The remainder stays below the original, so it fits back into RW bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[RW-1:0] : rem_i;
      div_o  <= div_i;
      quot_o <= {quot_i[QB-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> src/point_ray_distance_sphere_test_unit.sv
// ----------------------------------------------------------------------------
// point_ray_distance_sphere_test_unit
// Squared distance from a point to a ray, the ray parameter of the closest
// point and a sphere hit flag, from signed Q16.16 fixed-point coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Queries arrive on in_i and results leave on out_o, both valid/ready
//   channels; a transfer happens when valid and ready are high at a clock edge.
//   One query is taken every cycle while the skid register is empty, and
//   each query gives exactly one result, in order. The chain of divider
//   cells is QB = max(COORD_WIDTH + 2, 31) cells long. Six front stages form
//   the difference, the dot products, the two halves of each projection
//   product and the divider operands; the chain of cells produces one
//   quotient bit per cell for the ray parameter and the three projection
//   components; three back stages correct the difference and sum its squares
//   before the output register.
//   When the receiver stalls, one more result is parked in a skid register
//   and the whole pipeline then holds; in_i.ready is registered and falls
//   only while that skid register is occupied.
//   Reset clears all valid flags; no result is presented until a query
//   has passed through.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module point_ray_distance_sphere_test_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prd_in_if.sink     in_i,
  prd_out_if.source  out_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned QB   = (W + 2 > 31) ? W + 2 : 31;
  localparam int unsigned RW_P = 3 * W + 5;
  localparam int unsigned DW_P = 2 * W + 1;
  localparam int unsigned RW_T = 2 * W + 18;
  localparam int unsigned DW_T = 2 * W;
  localparam int unsigned SQW  = 2 * W + 8;
  localparam int unsigned SUMW = 2 * W + 10;
  localparam int unsigned XW   = (SUMW > 64) ? SUMW : 64;
  localparam int unsigned ML   = W + 2;

  logic en;

  // Coordinates: the low COORD_WIDTH bits of each field, or the field sign-extended from its top bit when wider.
  logic [prd_pkg::FIELD_W-1:0] p_raw [3];
  logic [prd_pkg::FIELD_W-1:0] o_raw [3];
  logic [prd_pkg::FIELD_W-1:0] d_raw [3];
  logic signed [W-1:0]         p_c [3];
  logic signed [W-1:0]         o_c [3];
  logic signed [W-1:0]         d_c [3];

  assign p_raw[0] = in_i.point_x;
  assign p_raw[1] = in_i.point_y;
  assign p_raw[2] = in_i.point_z;
  assign o_raw[0] = in_i.origin_x;
  assign o_raw[1] = in_i.origin_y;
  assign o_raw[2] = in_i.origin_z;
  assign d_raw[0] = in_i.dir_x;
  assign d_raw[1] = in_i.dir_y;
  assign d_raw[2] = in_i.dir_z;

  for (genvar i = 0; i < 3; i++) begin : g_coord
    if (W <= prd_pkg::FIELD_W) begin : g_narrow
      assign p_c[i] = p_raw[i][W-1:0];
      assign o_c[i] = o_raw[i][W-1:0];
      assign d_c[i] = d_raw[i][W-1:0];
    end else begin : g_wide
      assign p_c[i] = {{(W-prd_pkg::FIELD_W){p_raw[i][prd_pkg::FIELD_W-1]}}, p_raw[i]};
      assign o_c[i] = {{(W-prd_pkg::FIELD_W){o_raw[i][prd_pkg::FIELD_W-1]}}, o_raw[i]};
      assign d_c[i] = {{(W-prd_pkg::FIELD_W){d_raw[i][prd_pkg::FIELD_W-1]}}, d_raw[i]};
    end
  end

  // Front stage registers.
  logic                          v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [W:0]             diff1_q [3];
  logic signed [W-1:0]           dir1_q [3];
  logic [prd_pkg::RADIUS_W-1:0]  rad1_q, rad2_q, rad3_q, rad4_q, rad5_q;
  logic signed [W:0]             diff2_q [3];
  logic signed [W-1:0]           dir2_q [3];
  logic signed [2*W:0]           pd2_q [3];
  logic signed [2*W-1:0]         ps2_q [3];
  logic signed [W:0]             diff3_q [3];
  logic signed [W-1:0]           dir3_q [3];
  logic signed [2*W+2:0]         dot3_q;
  logic [2*W-1:0]                mm3_q;
  logic signed [W:0]             diff4_q [3];
  logic signed [2*W+2:0]         mlo4_q [3];
  logic signed [2*W:0]           mhi4_q [3];
  logic [2*W-1:0]                mm4_q;
  logic                          pos4_q, sat4_q;
  logic [RW_T-1:0]               tnum4_q;
  logic signed [W:0]             diff5_q [3];
  logic signed [3*W+2:0]         m5_q [3];
  logic [2*W-1:0]                mm5_q;
  logic                          pos5_q, sat5_q;
  logic [RW_T-1:0]               tnum5_q;

  logic [2*W+1:0]                dot3_mag;
  logic                          pos3;
  logic                          sat3;

  always_comb begin
    dot3_mag = dot3_q[2*W+1:0];
    pos3     = !dot3_q[2*W+2] && (dot3_q != '0) && (mm3_q != '0);
    sat3     = (2*W+17)'(dot3_mag) >= ((2*W+17)'(mm3_q) << 15);
  end

  // Valid flags of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Difference, products, dot sums and projection numerators. The product
  // of a direction component with the dot sum is formed from its low and
  // high halves of the dot sum and combined in the next stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        diff1_q[i] <= (W+1)'(p_c[i]) - (W+1)'(o_c[i]);
        dir1_q[i]  <= d_c[i];
        diff2_q[i] <= diff1_q[i];
        dir2_q[i]  <= dir1_q[i];
        pd2_q[i]   <= (2*W+1)'(diff1_q[i]) * (2*W+1)'(dir1_q[i]);
        ps2_q[i]   <= (2*W)'(dir1_q[i]) * (2*W)'(dir1_q[i]);
        diff3_q[i] <= diff2_q[i];
        dir3_q[i]  <= dir2_q[i];
        diff4_q[i] <= diff3_q[i];
        mlo4_q[i]  <= (2*W+3)'(dir3_q[i]) * (2*W+3)'($signed({1'b0, dot3_q[ML-1:0]}));
        mhi4_q[i]  <= (2*W+1)'(dir3_q[i]) * (2*W+1)'($signed(dot3_q[2*W+2:ML]));
        diff5_q[i] <= diff4_q[i];
        m5_q[i]    <= ((3*W+3)'(mhi4_q[i]) <<< ML) + (3*W+3)'(mlo4_q[i]);
      end
      rad1_q  <= in_i.radius;
      rad2_q  <= rad1_q;
      rad3_q  <= rad2_q;
      rad4_q  <= rad3_q;
      rad5_q  <= rad4_q;
      dot3_q  <= (2*W+3)'(pd2_q[0]) + (2*W+3)'(pd2_q[1]) + (2*W+3)'(pd2_q[2]);
      mm3_q   <= ps2_q[0][2*W-1:0] + ps2_q[1][2*W-1:0] + ps2_q[2][2*W-1:0];
      mm4_q   <= mm3_q;
      mm5_q   <= mm4_q;
      pos4_q  <= pos3;
      pos5_q  <= pos4_q;
      sat4_q  <= sat3;
      sat5_q  <= sat4_q;
      tnum4_q <= {dot3_mag, 16'b0};
      tnum5_q <= tnum4_q;
    end
  end

  // Divider chains: index 0 holds the operands, index k+1 the output of cell k.
  logic [RW_P-1:0]               prem  [3][QB+1];
  logic [DW_P-1:0]               pdiv  [3][QB+1];
  logic [QB-1:0]                 pquot [3][QB+1];
  logic [RW_T-1:0]               trem  [QB+1];
  logic [DW_T-1:0]               tdiv  [QB+1];
  logic [QB-1:0]                 tquot [QB+1];
  logic                          cv_q   [QB+1];
  logic                          cpos_q [QB+1];
  logic                          csat_q [QB+1];
  logic                          cneg_q [3][QB+1];
  logic signed [W:0]             cdiff_q [3][QB+1];
  logic [prd_pkg::RADIUS_W-1:0]  crad_q [QB+1];
  logic [RW_P-1:0]               prem0_q [3];
  logic [DW_P-1:0]               pdiv0_q;
  logic [RW_T-1:0]               trem0_q;
  logic [DW_T-1:0]               tdiv0_q;
  logic [3*W+2:0]                mabs [3];

  // Rounded projection: floor((2|m| + mm) / (2 mm)).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mabs[i] = m5_q[i][3*W+2] ? -m5_q[i] : m5_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prem0_q[i] <= RW_P'({mabs[i], 1'b0}) + RW_P'(mm5_q);
      end
      pdiv0_q <= {mm5_q, 1'b0};
      trem0_q <= tnum5_q;
      tdiv0_q <= mm5_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_op
    assign prem[i][0]  = prem0_q[i];
    assign pdiv[i][0]  = pdiv0_q;
    assign pquot[i][0] = '0;
  end
  assign trem[0]  = trem0_q;
  assign tdiv[0]  = tdiv0_q;
  assign tquot[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    for (genvar i = 0; i < 3; i++) begin : g_proj
      prd_div_cell #(
        .RW(RW_P), .DW(DW_P), .QB(QB), .SHIFT(QB - 1 - k)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (prem[i][k]),
        .div_i (pdiv[i][k]),
        .quot_i(pquot[i][k]),
        .rem_o (prem[i][k+1]),
        .div_o (pdiv[i][k+1]),
        .quot_o(pquot[i][k+1])
      );
    end
    prd_div_cell #(
      .RW(RW_T), .DW(DW_T), .QB(QB), .SHIFT(QB - 1 - k)
    ) u_tcell (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (trem[k]),
      .div_i (tdiv[k]),
      .quot_i(tquot[k]),
      .rem_o (trem[k+1]),
      .div_o (tdiv[k+1]),
      .quot_o(tquot[k+1])
    );
  end

  // Side data travelling alongside the cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) begin
        cv_q[k] <= 1'b0;
      end
    end else if (en) begin
      cv_q[0] <= v5_q;
      for (int k = 1; k <= QB; k++) begin
        cv_q[k] <= cv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cpos_q[0] <= pos5_q;
      csat_q[0] <= sat5_q;
      crad_q[0] <= rad5_q;
      for (int i = 0; i < 3; i++) begin
        cneg_q[i][0]  <= m5_q[i][3*W+2];
        cdiff_q[i][0] <= diff5_q[i];
      end
      for (int k = 1; k <= QB; k++) begin
        cpos_q[k] <= cpos_q[k-1];
        csat_q[k] <= csat_q[k-1];
        crad_q[k] <= crad_q[k-1];
        for (int i = 0; i < 3; i++) begin
          cneg_q[i][k]  <= cneg_q[i][k-1];
          cdiff_q[i][k] <= cdiff_q[i][k-1];
        end
      end
    end
  end

  // Back stages: corrected difference, squares, sum.
  logic                          vb1_q, vb2_q, vb3_q;
  logic signed [W+3:0]           nd1_q [3];
  logic [prd_pkg::T_W-1:0]       t1_q, t2_q, t3_q;
  logic [prd_pkg::RADIUS_W-1:0]  rb1_q;
  logic [SQW-1:0]                sq2_q [3];
  logic [2*prd_pkg::RADIUS_W-1:0] r2_q, r3_q;
  logic [SUMW-1:0]               dist3_q;
  logic signed [W+2:0]           qs [3];
  logic [prd_pkg::T_W-1:0]       t_res;
  logic signed [2*W+7:0]         sqs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!cpos_q[QB]) begin
        qs[i] = '0;
      end else if (cneg_q[i][QB]) begin
        qs[i] = -$signed({1'b0, pquot[i][QB][W+1:0]});
      end else begin
        qs[i] = $signed({1'b0, pquot[i][QB][W+1:0]});
      end
      sqs[i] = (2*W+8)'(nd1_q[i]) * (2*W+8)'(nd1_q[i]);
    end
    if (!cpos_q[QB]) begin
      t_res = '0;
    end else if (csat_q[QB]) begin
      t_res = prd_pkg::T_MAX;
    end else begin
      t_res = tquot[QB][prd_pkg::T_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q <= 1'b0;
      vb2_q <= 1'b0;
      vb3_q <= 1'b0;
    end else if (en) begin
      vb1_q <= cv_q[QB];
      vb2_q <= vb1_q;
      vb3_q <= vb2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nd1_q[i] <= (W+4)'(cdiff_q[i][QB]) - (W+4)'(qs[i]);
        sq2_q[i] <= sqs[i][SQW-1:0];
      end
      t1_q    <= t_res;
      rb1_q   <= crad_q[QB];
      t2_q    <= t1_q;
      r2_q    <= (2*prd_pkg::RADIUS_W)'(rb1_q) * (2*prd_pkg::RADIUS_W)'(rb1_q);
      t3_q    <= t2_q;
      r3_q    <= r2_q;
      dist3_q <= SUMW'(sq2_q[0]) + SUMW'(sq2_q[1]) + SUMW'(sq2_q[2]);
    end
  end

  // Saturation and hit decision on the exact sum.
  prd_pkg::res_t res;
  logic [XW-1:0] dist_ext;

  always_comb begin
    dist_ext    = XW'(dist3_q);
    res.param_t = t3_q;
    res.hit     = dist_ext < XW'(r3_q);
    res.dist_sq = (dist_ext > XW'(prd_pkg::DIST_MAX)) ? prd_pkg::DIST_MAX
                                                       : dist_ext[prd_pkg::DIST_W-1:0];
  end

  // Output register with a one-entry skid register behind it.
  logic          out_v_q, skid_v_q;
  prd_pkg::res_t out_q, skid_q;
  logic          out_take;

  assign en       = !skid_v_q;
  assign out_take = out_v_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        skid_v_q <= 1'b0;
      end
    end else if (vb3_q) begin
      if (out_v_q && !out_o.ready) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (vb3_q) begin
      if (out_v_q && !out_o.ready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_i.ready    = en;
  assign out_o.valid   = out_v_q;
  assign out_o.dist_sq = out_q.dist_sq;
  assign out_o.param_t = out_q.param_t;
  assign out_o.hit     = out_q.hit;

  // The skid register is only occupied behind a waiting result.
  `PRD_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q, "skid full without output")
  // The skid register only stays full after a stalled cycle.
  `PRD_ASSERT(a_skid_cause, clk_i, rst_ni, skid_v_q |-> $past(out_v_q && !out_o.ready), "skid without stall")
  // A hit means the distance is below radius squared, hence never saturated.
  `PRD_ASSERT_NEVER(a_hit_unsat, clk_i, rst_ni, out_v_q && out_q.hit && out_q.dist_sq[prd_pkg::DIST_W-1], "hit with huge distance")

endmodule

`default_nettype wire

>>> tb/tb_point_ray_distance_sphere_test_unit.sv
// ----------------------------------------------------------------------------
// tb_point_ray_distance_sphere_test_unit
// Streams point/ray/radius queries through the unit with random gaps on the
// query side and random stalls on the result side. Every accepted query is
// evaluated by a wide-integer model of the projection and saved in order;
// each result transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_point_ray_distance_sphere_test_unit;

  localparam int unsigned WW       = 200;  // width of the exact arithmetic
  localparam logic [31:0] ONE      = 32'h0001_0000;
  localparam int unsigned DRAIN_CY = 80;   // watched after the drain for stray results

  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    logic [31:0]                  px, py, pz;
    logic [31:0]                  ox, oy, oz;
    logic [31:0]                  dx, dy, dz;
    logic [prd_pkg::RADIUS_W-1:0] radius;
  } query_t;

  logic clk_i;
  logic rst_ni;

  prd_in_if  in_if ();
  prd_out_if out_if ();

  point_ray_distance_sphere_test_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Results still owed by the unit, oldest first.
  prd_pkg::res_t pending_results[$];
  int unsigned   error_count;
  int unsigned   queries_sent;
  int unsigned   results_checked;
  int unsigned   hits_seen;
  int unsigned   clamped_seen;
  bit            sender_burst;
  bit            receiver_burst;

  // Clock: 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Exact squared distance, ray parameter and hit flag of one query.
  function automatic prd_pkg::res_t project_point(input query_t q);
    wide_t         diff[3];
    wide_t         dir[3];
    wide_t         dot;
    wide_t         len_sq;
    wide_t         t;
    wide_t         m;
    wide_t         corr;
    wide_t         dist_sum;
    wide_t         r_sq;
    prd_pkg::res_t r;
    diff[0] = wide_t'($signed(q.px)) - wide_t'($signed(q.ox));
    diff[1] = wide_t'($signed(q.py)) - wide_t'($signed(q.oy));
    diff[2] = wide_t'($signed(q.pz)) - wide_t'($signed(q.oz));
    dir[0]  = wide_t'($signed(q.dx));
    dir[1]  = wide_t'($signed(q.dy));
    dir[2]  = wide_t'($signed(q.dz));
    dot    = diff[0] * dir[0] + diff[1] * dir[1] + diff[2] * dir[2];
    len_sq = dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2];
    t      = '0;
    // Only a positive dot with a nonzero direction moves the closest point.
    if (dot > 0 && len_sq != 0) begin
      t = (dot <<< 16) / len_sq;
      for (int i = 0; i < 3; i++) begin
        m    = dir[i] * dot;
        // Round half away from zero on the magnitude.
        corr = ((m < 0 ? -m : m) * 2 + len_sq) / (len_sq * 2);
        if (m < 0) corr = -corr;
        diff[i] = diff[i] - corr;
      end
    end
    dist_sum = diff[0] * diff[0] + diff[1] * diff[1] + diff[2] * diff[2];
    r_sq = wide_t'({1'b0, q.radius}) * wide_t'({1'b0, q.radius});
    r.dist_sq = (dist_sum > wide_t'({1'b0, prd_pkg::DIST_MAX})) ? prd_pkg::DIST_MAX
                                                                : dist_sum[prd_pkg::DIST_W-1:0];
    r.param_t = (t > wide_t'({1'b0, prd_pkg::T_MAX})) ? prd_pkg::T_MAX
                                                      : t[prd_pkg::T_W-1:0];
    r.hit     = (dist_sum < r_sq);
    return r;
  endfunction

  // Random coordinate of about the given number of significant bits.
  function automatic logic [31:0] rand_coord(input int unsigned bits);
    logic signed [31:0] v;
    v = $signed($urandom);
    return (bits >= 32) ? v : (v >>> (32 - bits));
  endfunction

  // Offers one query after a drawn gap and waits for its transfer.
  task automatic send_query(input query_t q);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.point_x  <= q.px;
    in_if.point_y  <= q.py;
    in_if.point_z  <= q.pz;
    in_if.origin_x <= q.ox;
    in_if.origin_y <= q.oy;
    in_if.origin_z <= q.oz;
    in_if.dir_x    <= q.dx;
    in_if.dir_y    <= q.dy;
    in_if.dir_z    <= q.dz;
    in_if.radius   <= q.radius;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(project_point(q));
    queries_sent++;
  endtask

  task automatic send_fields(input logic [31:0] px, py, pz, ox, oy, oz, dx, dy, dz,
                             input logic [prd_pkg::RADIUS_W-1:0] rad);
    query_t q;
    q = '{px, py, pz, ox, oy, oz, dx, dy, dz, rad};
    send_query(q);
  endtask

  // Extremes of the fields and the special cases of the projection.
  task automatic test_directed_cases();
    sender_burst = 1'b0;
    // Point on the ray: zero distance, radius zero is not a hit.
    send_fields(5 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, '0);
    send_fields(5 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 31'd1);
    // Distance exactly equal to the radius, then one step inside.
    send_fields(0, 3 * ONE, 0, 0, 0, 0, ONE, 0, 0, 31'(3 * ONE));
    send_fields(0, 3 * ONE, 0, 0, 0, 0, ONE, 0, 0, 31'(3 * ONE + 1));
    // Point behind the origin: parameter clamps to zero.
    send_fields(-32'sd7 * ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 31'(2 * ONE));
    // Perpendicular offset: dot is zero.
    send_fields(0, 0, 4 * ONE, ONE, 0, 0, 0, ONE, 0, 31'(5 * ONE));
    // Zero direction, positive and negative offsets.
    send_fields(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0, 0, 31'(4 * ONE));
    send_fields(-32'sd1, -32'sd1, -32'sd1, 0, 0, 0, 0, 0, 0, '1);
    // Tiny direction with a far point: parameter saturates.
    send_fields(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 32'd1, 0, 0, '1);
    // Extremes everywhere: distance saturates, hit decided exactly.
    send_fields(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '1);
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    send_fields(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1);
    // Oblique directions with rounded projection components.
    send_fields(3, 1, 0, 0, 0, 0, 32'd2, 32'd2, 0, 31'd2);
    send_fields(-32'sd3, -32'sd1, 0, 0, 0, 0, -32'sd2, -32'sd2, 0, 31'd2);
    send_fields(ONE + 1, -32'sd5, 7, -32'sd3, 2, -32'sd1, 32'd3, -32'sd1, 32'd1,
                31'd100);
    // Back to back with no gaps.
    sender_burst = 1'b1;
    send_fields(ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, 31'(ONE));
    send_fields(-32'sd1, 0, 0, 0, 0, 0, 0, 0, ONE, '1);
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
    sender_burst = 1'b0;
  endtask

  // Random queries mixing full-range, small, near-ray and zero-direction geometry.
  task automatic test_random_queries(input int unsigned n);
    query_t      q;
    int unsigned bits;
    int unsigned kind;
    logic [31:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      bits = (kind < 2) ? 32 : $urandom_range(4, 24);
      q.px = rand_coord(bits);
      q.py = rand_coord(bits);
      q.pz = rand_coord(bits);
      q.ox = rand_coord(bits);
      q.oy = rand_coord(bits);
      q.oz = rand_coord(bits);
      q.dx = rand_coord(bits);
      q.dy = rand_coord(bits);
      q.dz = rand_coord(bits);
      // Points near the ray, so that hits and small distances are common.
      if (kind >= 7) begin
        k    = $urandom_range(0, 15);
        q.dx = rand_coord(12);
        q.dy = rand_coord(12);
        q.dz = rand_coord(12);
        q.px = q.ox + q.dx * k + rand_coord(6);
        q.py = q.oy + q.dy * k + rand_coord(6);
        q.pz = q.oz + q.dz * k + rand_coord(6);
      end
      if (kind == 6) {q.dx, q.dy, q.dz} = '0;
      q.radius = (kind < 2) ? prd_pkg::RADIUS_W'($urandom)
                            : prd_pkg::RADIUS_W'($urandom >> (32 - $urandom_range(2, bits)));
      send_query(q);
    end
  endtask

  // Result side: random stalls, then check of every transfer.
  initial begin
    int unsigned stall;
    out_if.ready   <= 1'b0;
    receiver_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) receiver_burst = ~receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      check_result();
    end
  end

  task automatic check_result();
    prd_pkg::res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result with nothing outstanding: dist_sq %h param_t %h hit %b",
               $time, out_if.dist_sq, out_if.param_t, out_if.hit);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.hit) hits_seen++;
    if (want.param_t == 0) clamped_seen++;
    if (out_if.dist_sq !== want.dist_sq) begin
      $display("%0t: dist_sq expected %h actual %h", $time, want.dist_sq, out_if.dist_sq);
      error_count++;
    end
    if (out_if.param_t !== want.param_t) begin
      $display("%0t: param_t expected %h actual %h", $time, want.param_t, out_if.param_t);
      error_count++;
    end
    if (out_if.hit !== want.hit) begin
      $display("%0t: hit expected %b actual %b", $time, want.hit, out_if.hit);
      error_count++;
    end
  endtask

  // Main sequence.
  initial begin
    int unsigned drain;
    error_count     = 0;
    queries_sent    = 0;
    results_checked = 0;
    hits_seen       = 0;
    clamped_seen    = 0;
    sender_burst    = 1'b0;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.point_x  <= '0;
    in_if.point_y  <= '0;
    in_if.point_z  <= '0;
    in_if.origin_x <= '0;
    in_if.origin_y <= '0;
    in_if.origin_z <= '0;
    in_if.dir_x    <= '0;
    in_if.dir_y    <= '0;
    in_if.dir_z    <= '0;
    in_if.radius   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_queries(600);
    // Withdraw the last query at its own transfer edge.
    in_if.valid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    wait (pending_results.size() == 0);
    for (drain = 0; drain < DRAIN_CY; drain++) @(posedge clk_i);

    $display("Sent %0d queries and checked %0d results (%0d hits, %0d with t clamped).",
             queries_sent, results_checked, hits_seen, clamped_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/prd_pkg.sv
src/prd_if.sv
src/prd_div_cell.sv
src/point_ray_distance_sphere_test_unit.sv
tb/tb_point_ray_distance_sphere_test_unit.sv
